>>> hw/rtl/cttc_pkg.sv
package cttc_pkg;

	localparam int MaxLeavesDefault = 256;
	localparam logic [47:0] AccMax = 48'hFFFF_FFFF_FFFF;
	localparam logic [15:0] CntMax = 16'hFFFF;
	localparam logic [15:0] NoPos = 16'hFFFF;

	localparam logic OpReference = 1'b0;
	localparam logic OpCompare = 1'b1;

	typedef struct packed {
		logic        operation;
		logic [7:0]  leaf_id;
		logic [8:0]  descendant_count;
		logic [31:0] branch_weight;
		logic        tree_end;
	} item_in_t;

	typedef struct packed {
		logic [7:0]  matched_clusters;
		logic [47:0] distance_weight;
	} item_out_t;

	typedef struct packed {
		logic [15:0] low;
		logic [15:0] high;
		logic [15:0] size;
		logic [15:0] sub;
	} listing_t;

endpackage

>>> hw/rtl/cluster_table_tree_compare_unit.sv
// Weighted Robinson-Foulds distance by Day's cluster table. Reference-tree nodes
// (postorder) build the table; compare-tree nodes are matched through a listing
// stack. Once accepted, a reference node passes through the states RREAD and RWR, and
// a compare leaf through RREAD, CLEAF and MATCH. An internal compare node passes through
// RREAD and POP, then POPD and POP again for each child popped from the stack memory,
// then LOOK and MATCH, and LOOK and MATCH once more when the cluster is looked up at its
// high entry. Busy stays high until the unit is back in IDLE, where the next item is taken.
// After reset the table is cleared entry by entry while busy stays high.
// One result follows the compare node that carries tree_end, shown for a
// single cycle with result_valid; the receiver cannot hold it off.
module cluster_table_tree_compare_unit #(
	parameter int MAX_LEAVES = cttc_pkg::MaxLeavesDefault
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  cttc_pkg::item_in_t  item,
	output logic                result_valid,
	output cttc_pkg::item_out_t result
);

	localparam int LW = $clog2(MAX_LEAVES);
	localparam int NW = LW + 1;
	localparam int MaxNodes = 2 * MAX_LEAVES;

	typedef enum logic [8:0] {
		ST_CLEAR = 9'b000000001,
		ST_IDLE  = 9'b000000010,
		ST_RREAD = 9'b000000100,
		ST_RWR   = 9'b000001000,
		ST_CLEAF = 9'b000010000,
		ST_POP   = 9'b000100000,
		ST_POPD  = 9'b001000000,
		ST_LOOK  = 9'b010000000,
		ST_MATCH = 9'b100000000
	} state_t;

	state_t state_q;

	logic [15:0] leaf_pos_mem [MAX_LEAVES];
	logic [15:0] clow_mem [MAX_LEAVES];
	logic [15:0] chigh_mem [MAX_LEAVES];
	logic [31:0] cw_mem [MAX_LEAVES];
	logic [15:0] nls_mem [MaxNodes];
	cttc_pkg::listing_t stk_mem [MaxNodes];

	cttc_pkg::item_in_t itm_q;
	logic [NW:0] sp_q;
	logic [LW-1:0] leaf_cnt_q;
	logic [NW-1:0] node_idx_q;
	logic [15:0] last_leaf_q;
	logic pend_v_q;
	logic [15:0] pend_low_q, pend_high_q;
	logic [31:0] pend_w_q;
	logic [47:0] acc_q;
	logic [7:0] match_q;
	logic [LW-1:0] clr_q;
	cttc_pkg::listing_t lst_q;
	logic [15:0] rem_q;
	logic lookhi_q;

	logic [15:0] rd_lpos_q, rd_nls_q, rd_clow_q, rd_chigh_q;
	logic [31:0] rd_cw_q;
	cttc_pkg::listing_t rd_stk_q;

	logic          tw_en;
	logic [LW-1:0] tw_addr;
	logic [15:0]   tw_low, tw_high;
	logic [31:0]   tw_w;
	logic [LW-1:0] tr_addr;

	logic [47:0] acc_add;
	logic [48:0] acc_sum;
	logic [NW-1:0] back_idx;
	cttc_pkg::listing_t merged;
	logic [16:0] sz_sum, sb_sum;
	logic [31:0] min_w;
	logic [48:0] sub2;
	logic contiguous;
	logic [16:0] span;
	logic [NW:0] push_addr;
	logic [LW+7:0] lid_ext;
	logic [NW+8:0] desc_ext;
	logic hit, to_look, fire;
	logic [7:0] match_nx;
	logic [47:0] acc_nx;

	assign busy = (state_q != ST_IDLE);
	assign acc_add = {16'd0, itm_q.branch_weight};
	assign acc_sum = {1'b0, acc_q} + {1'b0, acc_add};
	assign lid_ext = {{LW{1'b0}}, itm_q.leaf_id};
	assign desc_ext = {{NW{1'b0}}, itm_q.descendant_count};
	assign back_idx = node_idx_q - desc_ext[NW-1:0];

	always_comb begin
		merged = lst_q;
		if (rd_stk_q.low < lst_q.low) merged.low = rd_stk_q.low;
		if (rd_stk_q.high > lst_q.high) merged.high = rd_stk_q.high;
		sz_sum = {1'b0, lst_q.size} + {1'b0, rd_stk_q.size};
		sb_sum = {1'b0, lst_q.sub} + {1'b0, rd_stk_q.sub};
		merged.size = sz_sum[16] ? cttc_pkg::CntMax : sz_sum[15:0];
		merged.sub = sb_sum[16] ? cttc_pkg::CntMax : sb_sum[15:0];
	end

	assign span = {1'b0, lst_q.high} - {1'b0, lst_q.low} + 17'd1;
	assign contiguous = (lst_q.size != 16'd0) && !(lst_q.high < lst_q.low)
		&& (span == {1'b0, lst_q.size});
	assign min_w = (rd_cw_q < itm_q.branch_weight) ? rd_cw_q : itm_q.branch_weight;
	assign sub2 = {16'd0, min_w, 1'b0};
	assign push_addr = (sp_q < (NW+1)'(MaxNodes)) ? sp_q : (NW+1)'(MaxNodes - 1);

	assign hit = contiguous && rd_clow_q == lst_q.low && rd_chigh_q == lst_q.high
		&& (lookhi_q ? lst_q.high : lst_q.low) < 16'(MAX_LEAVES);
	assign to_look = contiguous && !lookhi_q && !hit;
	assign fire = (state_q == ST_MATCH) && itm_q.tree_end && !to_look;
	assign match_nx = (hit && match_q != 8'd255) ? match_q + 8'd1 : match_q;
	assign acc_nx = hit ? (({1'b0, acc_q} > sub2) ? acc_q - sub2[47:0] : '0) : acc_q;

	always_comb begin
		tw_en = 1'b0;
		tw_addr = '0;
		tw_low = lst_q.low;
		tw_high = lst_q.high;
		tw_w = itm_q.branch_weight;
		tr_addr = lst_q.low[LW-1:0];
		if (state_q == ST_CLEAR) begin
			tw_en = 1'b1;
			tw_addr = clr_q;
			tw_low = cttc_pkg::NoPos;
			tw_high = cttc_pkg::NoPos;
			tw_w = '0;
		end else if (state_q == ST_RREAD && pend_v_q) begin
			tw_en = 1'b1;
			tw_addr = (itm_q.descendant_count == 9'd0 || itm_q.operation == cttc_pkg::OpCompare)
				? pend_high_q[LW-1:0] : pend_low_q[LW-1:0];
			tw_low = pend_low_q;
			tw_high = pend_high_q;
			tw_w = pend_w_q;
		end else if (state_q == ST_RWR && itm_q.descendant_count != 9'd0 && itm_q.tree_end) begin
			tw_en = 1'b1;
			tw_addr = last_leaf_q[LW-1:0];
			tw_low = rd_nls_q;
			tw_high = last_leaf_q;
		end
		if (state_q == ST_LOOK && lookhi_q) tr_addr = lst_q.high[LW-1:0];
	end

	always_ff @(posedge clk) begin
		if (tw_en) begin
			clow_mem[tw_addr] <= tw_low;
			chigh_mem[tw_addr] <= tw_high;
			cw_mem[tw_addr] <= tw_w;
		end
		rd_clow_q <= clow_mem[tr_addr];
		rd_chigh_q <= chigh_mem[tr_addr];
		rd_cw_q <= cw_mem[tr_addr];
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_RWR && itm_q.operation == cttc_pkg::OpReference
			&& itm_q.descendant_count == 9'd0)
			leaf_pos_mem[lid_ext[LW-1:0]] <= {{(16-LW){1'b0}}, leaf_cnt_q};
		rd_lpos_q <= leaf_pos_mem[lid_ext[LW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_RWR && itm_q.operation == cttc_pkg::OpReference)
			nls_mem[node_idx_q] <= (itm_q.descendant_count == 9'd0)
				? {{(16-LW){1'b0}}, leaf_cnt_q} : rd_nls_q;
		rd_nls_q <= nls_mem[back_idx];
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_CLEAF) begin
			stk_mem[push_addr[NW-1:0]] <= '{low: rd_lpos_q, high: rd_lpos_q,
				size: 16'd1, sub: 16'd1};
		end else if (state_q == ST_POP && !(rem_q != 16'd0 && sp_q != '0)) begin
			stk_mem[push_addr[NW-1:0]] <= lst_q;
		end
		rd_stk_q <= stk_mem[NW'(sp_q - (NW+1)'(1))];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q <= '0;
			sp_q <= '0;
			leaf_cnt_q <= '0;
			node_idx_q <= '0;
			last_leaf_q <= '0;
			pend_v_q <= 1'b0;
			acc_q <= '0;
			match_q <= '0;
			result_valid <= 1'b0;
			lookhi_q <= 1'b0;
		end else begin
			result_valid <= fire;
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + LW'(1);
					if (clr_q == LW'(MAX_LEAVES - 1)) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (start) begin
						itm_q <= item;
						state_q <= ST_RREAD;
					end
				end
				ST_RREAD: begin
					pend_v_q <= 1'b0;
					if (itm_q.operation == cttc_pkg::OpReference) begin
						state_q <= ST_RWR;
					end else begin
						leaf_cnt_q <= '0;
						node_idx_q <= '0;
						lst_q <= '{low: cttc_pkg::NoPos, high: 16'd0, size: 16'd0, sub: 16'd1};
						rem_q <= {7'd0, itm_q.descendant_count};
						state_q <= (itm_q.descendant_count == 9'd0) ? ST_CLEAF : ST_POP;
					end
				end
				ST_RWR: begin
					if (itm_q.descendant_count == 9'd0) begin
						last_leaf_q <= {{(16-LW){1'b0}}, leaf_cnt_q};
						leaf_cnt_q <= itm_q.tree_end ? '0 : leaf_cnt_q + LW'(1);
					end else begin
						acc_q <= acc_sum[48] ? cttc_pkg::AccMax : acc_sum[47:0];
						if (!itm_q.tree_end) begin
							pend_v_q <= 1'b1;
							pend_low_q <= rd_nls_q;
							pend_high_q <= last_leaf_q;
							pend_w_q <= itm_q.branch_weight;
						end else begin
							leaf_cnt_q <= '0;
						end
					end
					node_idx_q <= itm_q.tree_end ? '0 : node_idx_q + NW'(1);
					state_q <= ST_IDLE;
				end
				ST_CLEAF: begin
					if (sp_q < (NW+1)'(MaxNodes)) sp_q <= sp_q + (NW+1)'(1);
					state_q <= ST_MATCH;
					lookhi_q <= 1'b0;
					lst_q.size <= 16'd0;
				end
				ST_POP: begin
					if (rem_q != 16'd0 && sp_q != '0) begin
						sp_q <= sp_q - (NW+1)'(1);
						state_q <= ST_POPD;
					end else begin
						if (sp_q < (NW+1)'(MaxNodes)) sp_q <= sp_q + (NW+1)'(1);
						acc_q <= acc_sum[48] ? cttc_pkg::AccMax : acc_sum[47:0];
						lookhi_q <= 1'b0;
						state_q <= ST_LOOK;
					end
				end
				ST_POPD: begin
					lst_q <= merged;
					rem_q <= (rd_stk_q.sub >= rem_q) ? 16'd0 : rem_q - rd_stk_q.sub;
					state_q <= ST_POP;
				end
				ST_LOOK: begin
					state_q <= ST_MATCH;
				end
				ST_MATCH: begin
					lookhi_q <= to_look;
					state_q <= to_look ? ST_LOOK : ST_IDLE;
					if (fire) begin
						result.matched_clusters <= match_nx;
						result.distance_weight <= acc_nx;
						sp_q <= '0;
						match_q <= '0;
						acc_q <= '0;
					end else begin
						match_q <= match_nx;
						acc_q <= acc_nx;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

>>> tb/tb_cluster_table_tree_compare_unit.sv
`timescale 1ns / 100ps

module tb_cluster_table_tree_compare_unit;

	localparam int Leaves = 256;
	localparam int Nodes = 2 * Leaves;
	localparam int IdleLimit = 6000;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	cttc_pkg::item_in_t item;
	logic result_valid;
	cttc_pkg::item_out_t result;

	cluster_table_tree_compare_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.item(item),
		.result_valid(result_valid),
		.result(result)
	);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	// Own copy of the cluster table and the listing stack.
	logic [15:0] leaf_pos [Leaves];
	logic [15:0] clu_low [Leaves];
	logic [15:0] clu_high [Leaves];
	logic [31:0] clu_weight [Leaves];
	logic [15:0] node_start [Nodes];
	cttc_pkg::listing_t lst [Nodes];
	bit leaf_known [Leaves];
	bit start_known [Nodes];
	int sp, leaf_cnt, node_idx;
	logic [15:0] last_leaf;
	bit pend_v;
	logic [15:0] pend_low, pend_high;
	logic [31:0] pend_w;
	logic [47:0] dist_acc;
	int match_cnt;

	cttc_pkg::item_out_t distance_q [$];
	int errors = 0;
	int items_sent = 0;
	bit no_idle = 0;

	function automatic logic [47:0] acc_add(logic [47:0] a, logic [31:0] b);
		logic [48:0] s;
		s = {1'b0, a} + b;
		return s[48] ? cttc_pkg::AccMax : s[47:0];
	endfunction

	function automatic logic [15:0] cnt_add(logic [15:0] a, logic [15:0] b);
		logic [16:0] s;
		s = {1'b0, a} + b;
		return s[16] ? cttc_pkg::CntMax : s[15:0];
	endfunction

	task automatic place_cluster(logic [15:0] loc, logic [15:0] lo, logic [15:0] hi,
			logic [31:0] w);
		clu_low[loc[7:0]] = lo;
		clu_high[loc[7:0]] = hi;
		clu_weight[loc[7:0]] = w;
	endtask

	task automatic push_listing(cttc_pkg::listing_t l);
		if (sp < Nodes) begin
			lst[sp] = l;
			sp++;
		end else begin
			lst[Nodes - 1] = l;
		end
	endtask

	task automatic tree_distance_step(cttc_pkg::item_in_t it);
		cttc_pkg::listing_t l, c;
		int rem, back, pos;
		bit found;
		logic [31:0] b, m;
		logic [47:0] sub2;
		if (it.operation == cttc_pkg::OpReference) begin
			if (pend_v) begin
				place_cluster(it.descendant_count == 0 ? pend_high : pend_low,
					pend_low, pend_high, pend_w);
				pend_v = 0;
			end
			if (it.descendant_count == 0) begin
				leaf_pos[it.leaf_id] = 16'(leaf_cnt);
				leaf_known[it.leaf_id] = 1;
				node_start[node_idx] = 16'(leaf_cnt);
				start_known[node_idx] = 1;
				last_leaf = 16'(leaf_cnt);
				leaf_cnt = (leaf_cnt + 1) % Leaves;
			end else begin
				back = (node_idx + Nodes - it.descendant_count) % Nodes;
				node_start[node_idx] = node_start[back];
				start_known[node_idx] = 1;
				dist_acc = acc_add(dist_acc, it.branch_weight);
				if (it.tree_end) begin
					place_cluster(last_leaf, node_start[back], last_leaf, it.branch_weight);
				end else begin
					pend_v = 1;
					pend_low = node_start[back];
					pend_high = last_leaf;
					pend_w = it.branch_weight;
				end
			end
			node_idx = (node_idx + 1) % Nodes;
			if (it.tree_end) begin
				leaf_cnt = 0;
				node_idx = 0;
			end
			return;
		end
		if (pend_v) begin
			place_cluster(pend_high, pend_low, pend_high, pend_w);
			pend_v = 0;
		end
		leaf_cnt = 0;
		node_idx = 0;
		if (it.descendant_count == 0) begin
			l.low = leaf_pos[it.leaf_id];
			l.high = l.low;
			l.size = 1;
			l.sub = 1;
			push_listing(l);
		end else begin
			l.low = cttc_pkg::NoPos;
			l.high = 0;
			l.size = 0;
			l.sub = 1;
			rem = it.descendant_count;
			while (rem > 0 && sp > 0) begin
				sp--;
				c = lst[sp];
				if (c.low < l.low) l.low = c.low;
				if (c.high > l.high) l.high = c.high;
				l.size = cnt_add(l.size, c.size);
				l.sub = cnt_add(l.sub, c.sub);
				rem = (c.sub >= rem) ? 0 : rem - c.sub;
			end
			push_listing(l);
			dist_acc = acc_add(dist_acc, it.branch_weight);
			if (l.size != 0 && l.high >= l.low && l.high - l.low + 1 == l.size) begin
				found = 0;
				pos = 0;
				if (l.low < Leaves && clu_low[l.low] == l.low && clu_high[l.low] == l.high) begin
					found = 1;
					pos = l.low;
				end else if (l.high < Leaves && clu_low[l.high] == l.low
						&& clu_high[l.high] == l.high) begin
					found = 1;
					pos = l.high;
				end
				if (found) begin
					b = clu_weight[pos];
					m = (b < it.branch_weight) ? b : it.branch_weight;
					sub2 = {15'd0, m, 1'b0};
					dist_acc = (dist_acc > sub2) ? dist_acc - sub2 : '0;
					if (match_cnt < 255) match_cnt++;
				end
			end
		end
		if (it.tree_end) begin
			distance_q.insert(distance_q.size(),
				'{matched_clusters: 8'(match_cnt), distance_weight: dist_acc});
			sp = 0;
			match_cnt = 0;
			dist_acc = '0;
		end
	endtask

	task automatic send_item(cttc_pkg::item_in_t it, bit typed, cttc_pkg::item_out_t want);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 9);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		item <= it;
		do @(posedge clk); while (busy);
		tree_distance_step(it);
		if (typed && it.operation == cttc_pkg::OpCompare && it.tree_end) begin
			void'(distance_q.pop_back());
			distance_q.insert(distance_q.size(), want);
		end
		items_sent++;
		if ($urandom_range(0, 39) == 0) no_idle = !no_idle;
	endtask

	function automatic cttc_pkg::item_in_t mk(bit op, int id, int desc, logic [31:0] w,
			bit e);
		cttc_pkg::item_in_t it;
		it.operation = op;
		it.leaf_id = 8'(id);
		it.descendant_count = 9'(desc);
		it.branch_weight = w;
		it.tree_end = e;
		return it;
	endfunction

	function automatic logic [31:0] rand_weight();
		case ($urandom_range(0, 3))
			0: return $urandom_range(0, 255);
			1: return 32'hFFFF_FFFF - $urandom_range(0, 3);
			default: return $urandom;
		endcase
	endfunction

	// Random postorder tree over the given leaf ids; the root carries tree_end when ends is set.
	function automatic void build_tree(bit op, int ids[$], bit ends,
			ref cttc_pkg::item_in_t tree[$]);
		int sizes [$];
		int i, k, total;
		tree = {};
		i = 0;
		while (i < ids.size() || sizes.size() > 1) begin
			if (i < ids.size() && (sizes.size() < 2 || $urandom_range(0, 1))) begin
				tree.insert(tree.size(), mk(op, ids[i], 0, 0, 0));
				sizes.insert(sizes.size(), 1);
				i++;
			end else begin
				k = $urandom_range(2, sizes.size() < 3 ? sizes.size() : 3);
				total = 0;
				repeat (k) total += sizes.pop_back();
				tree.insert(tree.size(), mk(op, $urandom, total, rand_weight(), 0));
				sizes.insert(sizes.size(), total + 1);
			end
		end
		tree[tree.size() - 1].tree_end = ends;
	endfunction

	typedef struct {
		cttc_pkg::item_in_t it;
		bit typed;
		cttc_pkg::item_out_t want;
	} row_t;

	always @(posedge clk) begin
		cttc_pkg::item_out_t exp_r;
		if (result_valid) begin
			if (distance_q.size() == 0) begin
				$display("%0t: result with nothing expected: expected none, actual %h/%h",
					$time, result.matched_clusters, result.distance_weight);
				errors++;
			end else begin
				exp_r = distance_q.pop_front();
				if (result.matched_clusters !== exp_r.matched_clusters) begin
					$display("%0t: matched_clusters expected %0d, actual %0d", $time,
						exp_r.matched_clusters, result.matched_clusters);
					errors++;
				end
				if (result.distance_weight !== exp_r.distance_weight) begin
					$display("%0t: distance_weight expected %h, actual %h", $time,
						exp_r.distance_weight, result.distance_weight);
					errors++;
				end
			end
		end
	end

	int idle_cycles = 0;
	always @(posedge clk) begin
		if ((start && !busy) || result_valid || !arst_n) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IdleLimit) begin
			$display("== FAIL ==");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		row_t rows [$];
		cttc_pkg::item_in_t ref_tree [$];
		cttc_pkg::item_in_t cmp_tree [$];
		int ids [$];
		int pool [$];
		int n;
		cttc_pkg::item_in_t it;
		start <= 1'b0;
		item <= '0;
		arst_n <= 1'b0;
		for (int i = 0; i < Leaves; i++) begin
			leaf_pos[i] = 0;
			clu_low[i] = 16'hFFFF;
			clu_high[i] = 16'hFFFF;
			clu_weight[i] = 0;
			leaf_known[i] = 0;
		end
		for (int i = 0; i < Nodes; i++) begin
			node_start[i] = 0;
			start_known[i] = 0;
			lst[i] = '0;
		end
		sp = 0;
		leaf_cnt = 0;
		node_idx = 0;
		last_leaf = 0;
		pend_v = 0;
		pend_low = 0;
		pend_high = 0;
		pend_w = 0;
		dist_acc = '0;
		match_cnt = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// An empty listing still adds its weight, also with a count of 510.
		rows.insert(rows.size(), '{mk(cttc_pkg::OpCompare, 0, 1, 32'h0001_0000, 1), 1,
			'{8'd0, 48'h1_0000}});
		rows.insert(rows.size(), '{mk(cttc_pkg::OpCompare, 0, 510, 32'hFFFF_FFFF, 1), 1,
			'{8'd0, 48'hFFFF_FFFF}});
		// The same two-leaf tree on both sides gives one match.
		rows.insert(rows.size(), '{mk(cttc_pkg::OpReference, 0, 0, 0, 0), 0, '0});
		rows.insert(rows.size(), '{mk(cttc_pkg::OpReference, 255, 0, 0, 0), 0, '0});
		rows.insert(rows.size(), '{mk(cttc_pkg::OpReference, 0, 2, 32'h0001_0000, 1), 0, '0});
		rows.insert(rows.size(), '{mk(cttc_pkg::OpCompare, 255, 0, 0, 0), 0, '0});
		rows.insert(rows.size(), '{mk(cttc_pkg::OpCompare, 0, 0, 0, 0), 0, '0});
		rows.insert(rows.size(), '{mk(cttc_pkg::OpCompare, 0, 2, 32'h0003_0000, 1), 1,
			'{8'd1, 48'h2_0000}});
		// Lookahead placement, then a reference tree left without its end.
		rows.insert(rows.size(), '{mk(cttc_pkg::OpReference, 7, 0, 0, 0), 0, '0});
		rows.insert(rows.size(), '{mk(cttc_pkg::OpReference, 8, 0, 0, 0), 0, '0});
		rows.insert(rows.size(), '{mk(cttc_pkg::OpReference, 0, 2, 5, 0), 0, '0});
		rows.insert(rows.size(), '{mk(cttc_pkg::OpReference, 9, 0, 0, 0), 0, '0});
		rows.insert(rows.size(), '{mk(cttc_pkg::OpReference, 0, 4, 6, 0), 0, '0});
		rows.insert(rows.size(), '{mk(cttc_pkg::OpCompare, 7, 0, 0, 0), 0, '0});
		rows.insert(rows.size(), '{mk(cttc_pkg::OpCompare, 8, 0, 0, 0), 0, '0});
		rows.insert(rows.size(), '{mk(cttc_pkg::OpCompare, 0, 2, 3, 0), 0, '0});
		rows.insert(rows.size(), '{mk(cttc_pkg::OpCompare, 9, 0, 0, 0), 0, '0});
		rows.insert(rows.size(), '{mk(cttc_pkg::OpCompare, 0, 4, 32'h8000_0000, 0), 0, '0});
		// A short stack ends the popping early.
		rows.insert(rows.size(), '{mk(cttc_pkg::OpCompare, 0, 300, 32'hFFFF_FFFF, 1), 0, '0});
		foreach (rows[i]) send_item(rows[i].it, rows[i].typed, rows[i].want);

		start <= 1'b0;
		while (distance_q.size() != 0) @(posedge clk);

		while (items_sent < 830) begin
			if ($urandom_range(0, 4) != 0) begin
				n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(2, 12);
				pool = {};
				for (int i = 0; i < 256; i++) pool.insert(pool.size(), i);
				pool.shuffle();
				ids = pool[0:n-1];
				build_tree(cttc_pkg::OpReference, ids, $urandom_range(0, 9) != 0, ref_tree);
				if ($urandom_range(0, 1)) begin
					cmp_tree = ref_tree;
					foreach (cmp_tree[i]) begin
						cmp_tree[i].operation = cttc_pkg::OpCompare;
						cmp_tree[i].branch_weight = rand_weight();
					end
					cmp_tree[cmp_tree.size() - 1].tree_end = 1;
				end else begin
					ids.shuffle();
					build_tree(cttc_pkg::OpCompare, ids, 1, cmp_tree);
				end
				foreach (ref_tree[i]) send_item(ref_tree[i], 0, '0);
				foreach (cmp_tree[i]) send_item(cmp_tree[i], 0, '0);
			end else begin
				repeat ($urandom_range(1, 8)) begin
					it = mk($urandom_range(0, 1), $urandom, $urandom_range(0, 4) == 0 ?
						$urandom_range(0, 510) : $urandom_range(0, 3), rand_weight(),
						$urandom_range(0, 4) == 0);
					if (it.operation == cttc_pkg::OpCompare && it.descendant_count == 0
							&& !leaf_known[it.leaf_id])
						it.descendant_count = $urandom_range(1, 510);
					if (it.operation == cttc_pkg::OpReference && it.descendant_count != 0
							&& !start_known[(node_idx + Nodes - it.descendant_count) % Nodes])
						it.descendant_count = 0;
					send_item(it, 0, '0);
				end
			end
		end

		start <= 1'b0;
		while (distance_q.size() != 0) @(posedge clk);
		repeat (600) @(posedge clk);
		if (errors == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
